// ----- hdl/bcpp_pkg.sv -----
// ----------------------------------------------------------------------------
// bcpp_pkg
// Shared types and constants of the block class placement policy.
// ----------------------------------------------------------------------------
package bcpp_pkg;

    localparam int TABLE_ENTRIES   = 65536;
    localparam int TABLE_AW        = $clog2(TABLE_ENTRIES);
    localparam int BLOCK_SIZE_LOG2 = 21;

    localparam int ADDR_W   = 64;
    localparam int BLOCKS_W = 17;
    localparam int MODE_W   = 2;
    localparam int CLASS_W  = 2;
    localparam int PLACE_W  = 2;
    localparam int SEL_W    = 3;
    localparam int INDEX_W  = 16;
    localparam int CNT_W    = 64;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        REQ_ACTIVATE = 2'd0,
        REQ_ACCESS   = 2'd1,
        REQ_WRITE    = 2'd2,
        REQ_READ     = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAYOUT_BASE   = 2'd0,
        CFG_LAYOUT_BLOCKS = 2'd1,
        CFG_POLICY_MODE   = 2'd2,
        CFG_LAYOUT_READY  = 2'd3
    } cfg_idx_t;

    localparam logic [CLASS_W-1:0] CLASS_DEFAULT = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_HOT     = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_SHARED  = 2'd3;

    localparam logic [PLACE_W-1:0] PLACE_NONE = 2'd0;
    localparam logic [PLACE_W-1:0] PLACE_HEAD = 2'd1;
    localparam logic [PLACE_W-1:0] PLACE_TAIL = 2'd2;

    localparam logic [MODE_W-1:0] MODE_PAGE_LIFO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HOT_LIFO  = 2'd2;

    localparam int CNT_ACTIVATE    = 0;
    localparam int CNT_MAPPED      = 1;
    localparam int CNT_HOT_TAIL    = 2;
    localparam int CNT_COLD_HEAD   = 3;
    localparam int CNT_SHARED_TAIL = 4;
    localparam int CNT_DEFAULT     = 5;
    localparam int CNT_ACCESS      = 6;
    localparam int CNT_NUM         = 7;

    typedef struct packed {
        logic clear;
        logic capture;
        logic check;
        logic apply;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

endpackage

// ----- hdl/bcpp_ctrl.sv -----
// ----------------------------------------------------------------------------
// bcpp_ctrl
// Sequencer: table clearing sweep after reset, then capture, check and
// apply steps for each request.
// ----------------------------------------------------------------------------
module bcpp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bcpp_pkg::status_t status,
    output bcpp_pkg::cmd_t    cmd,
    output logic              busy
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_APPLY
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: state_next = S_APPLY;
            S_APPLY: state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign cmd.clear   = (state_reg == S_CLEAR);
    assign cmd.capture = (state_reg == S_IDLE) && start;
    assign cmd.check   = (state_reg == S_CHECK);
    assign cmd.apply   = (state_reg == S_APPLY);

endmodule

// ----- hdl/bcpp_datapath.sv -----
// ----------------------------------------------------------------------------
// bcpp_datapath
// Configuration registers, class table memory, range checks, event
// counters and the result register.
// ----------------------------------------------------------------------------
module bcpp_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bcpp_pkg::cmd_t                       cmd,
    output bcpp_pkg::status_t                    status,
    input  logic                                 cfg_write,
    input  logic [bcpp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bcpp_pkg::ADDR_W-1:0]          cfg_data,
    input  logic [1:0]                           req_type,
    input  logic [bcpp_pkg::ADDR_W-1:0]          block_address,
    input  logic                                 block_present,
    input  logic [bcpp_pkg::INDEX_W-1:0]         entry_index,
    input  logic [bcpp_pkg::CLASS_W-1:0]         entry_class,
    input  logic [bcpp_pkg::SEL_W-1:0]           counter_select,
    output logic                                 done,
    output logic [bcpp_pkg::PLACE_W-1:0]         placement,
    output logic [bcpp_pkg::CNT_W-1:0]           counter_value
);

    logic [bcpp_pkg::ADDR_W-1:0]   layout_base_reg;
    logic [bcpp_pkg::BLOCKS_W-1:0] layout_blocks_reg;
    logic [bcpp_pkg::MODE_W-1:0]   policy_mode_reg;
    logic                          layout_ready_reg;

    bcpp_pkg::req_t                req_reg;
    logic [bcpp_pkg::ADDR_W-1:0]   addr_reg;
    logic                          present_reg;
    logic [bcpp_pkg::INDEX_W-1:0]  eidx_reg;
    logic [bcpp_pkg::CLASS_W-1:0]  ecls_reg;
    logic [bcpp_pkg::SEL_W-1:0]    sel_reg;

    logic [bcpp_pkg::TABLE_AW-1:0] clr_addr_reg;
    logic [bcpp_pkg::CLASS_W-1:0]  class_table [bcpp_pkg::TABLE_ENTRIES];
    logic [bcpp_pkg::CLASS_W-1:0]  cls_reg;
    logic                          ok_reg;

    logic [bcpp_pkg::CNT_W-1:0]    counter_reg [bcpp_pkg::CNT_NUM];
    logic [bcpp_pkg::CNT_NUM-1:0]  inc;

    logic                          done_reg;
    logic [bcpp_pkg::PLACE_W-1:0]  placement_reg;
    logic [bcpp_pkg::CNT_W-1:0]    counter_value_reg;

    logic [bcpp_pkg::ADDR_W:0]     diff;
    logic [bcpp_pkg::ADDR_W-1:0]   blk;
    logic                          ok_next;
    logic                          wr_en;
    logic [bcpp_pkg::PLACE_W-1:0]  place_next;
    logic [bcpp_pkg::CNT_W-1:0]    cval_next;

    assign status.clear_last = (clr_addr_reg == {bcpp_pkg::TABLE_AW{1'b1}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_base_reg   <= '0;
            layout_blocks_reg <= '0;
            policy_mode_reg   <= bcpp_pkg::MODE_PAGE_LIFO;
            layout_ready_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (bcpp_pkg::cfg_idx_t'(cfg_index))
                bcpp_pkg::CFG_LAYOUT_BASE:   layout_base_reg   <= cfg_data;
                bcpp_pkg::CFG_LAYOUT_BLOCKS:
                    layout_blocks_reg <= cfg_data[bcpp_pkg::BLOCKS_W-1:0];
                bcpp_pkg::CFG_POLICY_MODE:
                    policy_mode_reg   <= cfg_data[bcpp_pkg::MODE_W-1:0];
                bcpp_pkg::CFG_LAYOUT_READY:  layout_ready_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg     <= bcpp_pkg::req_t'(req_type);
            addr_reg    <= block_address;
            present_reg <= block_present;
            eidx_reg    <= entry_index;
            ecls_reg    <= entry_class;
            sel_reg     <= counter_select;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Borrow of the subtraction marks an address below the base.
    assign diff = {1'b0, addr_reg} - {1'b0, layout_base_reg};
    assign blk  = diff[bcpp_pkg::ADDR_W-1:0] >> bcpp_pkg::BLOCK_SIZE_LOG2;

    always_comb
    begin
        ok_next = layout_ready_reg && (layout_blocks_reg != '0) && present_reg
                  && !diff[bcpp_pkg::ADDR_W]
                  && (blk < bcpp_pkg::ADDR_W'(layout_blocks_reg))
                  && (blk < bcpp_pkg::ADDR_W'(bcpp_pkg::TABLE_ENTRIES));
    end

    assign wr_en = cmd.check && (req_reg == bcpp_pkg::REQ_WRITE)
                   && (32'(eidx_reg) < 32'(bcpp_pkg::TABLE_ENTRIES));

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            class_table[clr_addr_reg] <= bcpp_pkg::CLASS_DEFAULT;
        end
        else if (wr_en)
        begin
            class_table[bcpp_pkg::TABLE_AW'(eidx_reg)] <= ecls_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            cls_reg <= class_table[blk[bcpp_pkg::TABLE_AW-1:0]];
            ok_reg  <= ok_next;
        end
    end

    always_comb
    begin
        inc        = '0;
        place_next = bcpp_pkg::PLACE_NONE;
        cval_next  = '0;
        case (req_reg)
            bcpp_pkg::REQ_ACTIVATE:
            begin
                inc[bcpp_pkg::CNT_ACTIVATE] = 1'b1;
                if (!ok_reg || (cls_reg == bcpp_pkg::CLASS_DEFAULT))
                begin
                    inc[bcpp_pkg::CNT_DEFAULT] = 1'b1;
                end
                else
                begin
                    inc[bcpp_pkg::CNT_MAPPED] = 1'b1;
                    if (cls_reg == bcpp_pkg::CLASS_SHARED)
                    begin
                        inc[bcpp_pkg::CNT_SHARED_TAIL] = 1'b1;
                        place_next = bcpp_pkg::PLACE_TAIL;
                    end
                    else if ((cls_reg == bcpp_pkg::CLASS_HOT)
                             && (policy_mode_reg == bcpp_pkg::MODE_HOT_LIFO))
                    begin
                        inc[bcpp_pkg::CNT_HOT_TAIL] = 1'b1;
                        place_next = bcpp_pkg::PLACE_TAIL;
                    end
                    else
                    begin
                        inc[bcpp_pkg::CNT_COLD_HEAD] = 1'b1;
                        place_next = bcpp_pkg::PLACE_HEAD;
                    end
                end
            end
            bcpp_pkg::REQ_ACCESS: inc[bcpp_pkg::CNT_ACCESS] = 1'b1;
            bcpp_pkg::REQ_READ:
            begin
                if (32'(sel_reg) < 32'(bcpp_pkg::CNT_NUM))
                begin
                    cval_next = counter_reg[sel_reg];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bcpp_pkg::CNT_NUM; i++)
            begin
                counter_reg[i] <= '0;
            end
        end
        else if (cmd.apply)
        begin
            for (int i = 0; i < bcpp_pkg::CNT_NUM; i++)
            begin
                if (inc[i])
                begin
                    counter_reg[i] <= counter_reg[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.apply;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            placement_reg     <= place_next;
            counter_value_reg <= cval_next;
        end
    end

    assign done          = done_reg;
    assign placement     = placement_reg;
    assign counter_value = counter_value_reg;

endmodule

// ----- hdl/block_class_placement_policy_top.sv -----
// ----------------------------------------------------------------------------
// block_class_placement_policy_top
// Placement decision for activated memory blocks from a 2-bit class table,
// with class entry writes, access counting and event counter reads.
//
// Usage:
//   Request: drive the request fields and raise start; the request transfers
//   at the clock edge where start is high and busy is low.
//   Result: done pulses for one cycle with placement and counter_value;
//   it follows the transfer through the check and apply steps and the
//   output register. The receiver cannot stall; results are never held.
//   Pacing: no new request transfers until the last one has passed the
//   class table read and the counter update that follows it. The next
//   request may transfer in the cycle that done is shown.
//   Configuration: cfg_write with cfg_index and cfg_data writes a register
//   at once; write only while no request is in flight.
//   Reset: configuration registers, counters and done clear at once; the
//   class table is then swept to default entry by entry with busy high.
// ----------------------------------------------------------------------------
module block_class_placement_policy_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    output logic                                 done,
    input  logic                                 cfg_write,
    input  logic [bcpp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bcpp_pkg::ADDR_W-1:0]          cfg_data,
    input  logic [1:0]                           req_type,
    input  logic [bcpp_pkg::ADDR_W-1:0]          block_address,
    input  logic                                 block_present,
    input  logic [bcpp_pkg::INDEX_W-1:0]         entry_index,
    input  logic [bcpp_pkg::CLASS_W-1:0]         entry_class,
    input  logic [bcpp_pkg::SEL_W-1:0]           counter_select,
    output logic [bcpp_pkg::PLACE_W-1:0]         placement,
    output logic [bcpp_pkg::CNT_W-1:0]           counter_value
);

    bcpp_pkg::cmd_t    cmd;
    bcpp_pkg::status_t status;

    bcpp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    bcpp_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_type       (req_type),
        .block_address  (block_address),
        .block_present  (block_present),
        .entry_index    (entry_index),
        .entry_class    (entry_class),
        .counter_select (counter_select),
        .done           (done),
        .placement      (placement),
        .counter_value  (counter_value)
    );

endmodule
